// ----- rtl/sof_pkg.sv -----
// ---------------------------------------------------------------------------
// sof_pkg: shared types and constants for the sphere overlap search
// Table geometry, entry layout, scan state codes and the status group
// passed from the distance pipeline to the scan control.
// ---------------------------------------------------------------------------
package sof_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int HIT_IDX_W   = 8;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic [14:0]        radius;
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } sof_entry_t;

    typedef struct packed {
        logic             pending;
        logic             valid;
        logic             hit;
        logic [IDX_W-1:0] index;
    } sof_stat_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_REPORT
    } sof_state_t;

endpackage

// ----- rtl/sof_dist.sv -----
// ---------------------------------------------------------------------------
// sof_dist: three-stage sphere overlap test
// Stage 1 takes centre differences and the radius sum, stage 2 squares
// them, stage 3 adds the distance terms and compares against the radius
// sum squared. Flush drops every beat in flight.
// ---------------------------------------------------------------------------
module sof_dist
    import sof_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             flush,
    input  logic             in_valid,
    input  logic [IDX_W-1:0] in_index,
    input  sof_entry_t       probe,
    input  sof_entry_t       entry,
    output sof_stat_t        stat
);

    logic               s1_vld_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic signed [16:0] dx_reg, dy_reg, dz_reg;
    logic [15:0]        rs_reg;

    logic               s2_vld_reg;
    logic [IDX_W-1:0]   s2_idx_reg;
    logic [31:0]        sqx_reg, sqy_reg, sqz_reg, rsq_reg;

    logic               s3_vld_reg;
    logic [IDX_W-1:0]   s3_idx_reg;
    logic               s3_hit_reg;

    logic signed [16:0] dx, dy, dz;
    logic [15:0]        rs;
    logic signed [33:0] sqx, sqy, sqz;
    logic [31:0]        rsq;
    logic [33:0]        dist_sq;
    logic               hit;

    always_comb
    begin
        dx      = {probe.x[15], probe.x} - {entry.x[15], entry.x};
        dy      = {probe.y[15], probe.y} - {entry.y[15], entry.y};
        dz      = {probe.z[15], probe.z} - {entry.z[15], entry.z};
        rs      = {1'b0, probe.radius} + {1'b0, entry.radius};
        sqx     = 34'(dx_reg) * 34'(dx_reg);
        sqy     = 34'(dy_reg) * 34'(dy_reg);
        sqz     = 34'(dz_reg) * 34'(dz_reg);
        rsq     = 32'(rs_reg) * 32'(rs_reg);
        dist_sq = {2'b00, sqx_reg} + {2'b00, sqy_reg} + {2'b00, sqz_reg};
        // touching spheres are not a hit
        hit     = dist_sq < {2'b00, rsq_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= in_valid && !flush;
            s2_vld_reg <= s1_vld_reg && !flush;
            s3_vld_reg <= s2_vld_reg && !flush;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= in_index;
        dx_reg     <= dx;
        dy_reg     <= dy;
        dz_reg     <= dz;
        rs_reg     <= rs;
        s2_idx_reg <= s1_idx_reg;
        // squares of 17-bit differences stay below 2^32
        sqx_reg    <= sqx[31:0];
        sqy_reg    <= sqy[31:0];
        sqz_reg    <= sqz[31:0];
        rsq_reg    <= rsq;
        s3_idx_reg <= s2_idx_reg;
        s3_hit_reg <= hit;
    end

    assign stat.pending = s1_vld_reg || s2_vld_reg;
    assign stat.valid   = s3_vld_reg;
    assign stat.hit     = s3_hit_reg;
    assign stat.index   = s3_idx_reg;

endmodule

// ----- rtl/sphere_overlap_first_hit.sv -----
// ---------------------------------------------------------------------------
// sphere_overlap_first_hit: first-hit sphere/sphere overlap search
// Sphere table in one synchronous memory, scanned through a pipelined
// distance test that stops at the lowest overlapping entry.
// ---------------------------------------------------------------------------
// Usage:
//   An item is taken at a clock edge with start high and busy low.
//   kind = 0 writes one table entry (x, y, z, radius) at entry_index in that
//   same edge; slots beyond the depth are dropped. A load gives no result
//   and keeps busy low, so loads may follow back to back.
//   kind = 1 runs a query with the probe sphere and object_count (saturated
//   to the depth). busy rises the next cycle and stays high until done.
//   The table memory has one read port, so the scan reads one entry per
//   cycle; a query stops at its first hit or once every entry is tested,
//   and a query with a zero count goes straight to its result beat.
//   done is high for exactly one cycle with hit_found and hit_index; the
//   receiver cannot stall, so the beat must be taken in that cycle.
//   Reset clears the control; table contents are undefined until loaded.
// ---------------------------------------------------------------------------
module sphere_overlap_first_hit
    import sof_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 kind,
    input  logic [7:0]           entry_index,
    input  logic signed [15:0]   pos_x,
    input  logic signed [15:0]   pos_y,
    input  logic signed [15:0]   pos_z,
    input  logic [14:0]          radius,
    input  logic [8:0]           object_count,
    output logic                 done,
    output logic                 hit_found,
    output logic [HIT_IDX_W-1:0] hit_index
);

    sof_entry_t       mem [TABLE_DEPTH];

    sof_state_t       state_reg, state_next;
    sof_entry_t       probe_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] issue_cnt_reg;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    sof_entry_t       rd_q_reg;
    logic             hit_found_reg;
    logic [HIT_IDX_W-1:0] hit_index_reg;

    sof_entry_t       wr_data;
    logic             accept;
    logic             load_we;
    logic             query_go;
    logic [CNT_W-1:0] count_sat;
    logic             issuing;
    logic             issue;
    logic             hit_now;
    logic             flush;
    logic             scan_empty;
    logic [31:0]      hit_idx_ext;
    sof_stat_t        stat;

    assign accept   = start && !busy;
    assign load_we  = accept && (kind == KIND_LOAD) && (32'(entry_index) < TABLE_DEPTH);
    assign query_go = accept && (kind == KIND_QUERY);

    assign count_sat = (32'(object_count) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                          : CNT_W'(object_count);

    assign wr_data.x      = pos_x;
    assign wr_data.y      = pos_y;
    assign wr_data.z      = pos_z;
    assign wr_data.radius = radius;

    assign issuing    = issue_cnt_reg != count_reg;
    assign hit_now    = stat.valid && stat.hit;
    assign scan_empty = !issuing && !rd_vld_reg && !stat.pending;
    assign hit_idx_ext = 32'(stat.index);

    // table memory: one write port for loads, one read port for the scan
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            mem[IDX_W'(entry_index)] <= wr_data;
        end
        rd_q_reg <= mem[issue_cnt_reg[IDX_W-1:0]];
    end

    sof_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .flush    (flush),
        .in_valid (rd_vld_reg),
        .in_index (rd_idx_reg),
        .probe    (probe_reg),
        .entry    (rd_q_reg),
        .stat     (stat)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (query_go)
                begin
                    state_next = (count_sat == '0) ? S_REPORT : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (hit_now || scan_empty)
                begin
                    state_next = S_REPORT;
                end
            end
            S_REPORT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy  = 1'b1;
        done  = 1'b0;
        issue = 1'b0;
        flush = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
            end
            S_SCAN:
            begin
                issue = issuing && !hit_now;
                // drop later entries once the first hit is in
                flush = hit_now;
            end
            S_REPORT:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            issue_cnt_reg <= '0;
            rd_vld_reg    <= 1'b0;
            hit_found_reg <= 1'b0;
            hit_index_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= issue;
            if (query_go)
            begin
                count_reg     <= count_sat;
                issue_cnt_reg <= '0;
                hit_found_reg <= 1'b0;
                hit_index_reg <= '0;
            end
            else
            begin
                if (issue)
                begin
                    issue_cnt_reg <= issue_cnt_reg + 1'b1;
                end
                if (state_reg == S_SCAN && hit_now)
                begin
                    hit_found_reg <= 1'b1;
                    hit_index_reg <= hit_idx_ext[HIT_IDX_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_go)
        begin
            probe_reg <= wr_data;
        end
        rd_idx_reg <= issue_cnt_reg[IDX_W-1:0];
    end

    assign hit_found = hit_found_reg;
    assign hit_index = hit_index_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("result beat without a query in progress");

    a_miss_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit_found) |-> (hit_index == '0))
        else $error("miss reported with a nonzero index");

    a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> (issue_cnt_reg < count_reg))
        else $error("scan read beyond the query count");

    a_query_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == KIND_QUERY) |=> busy)
        else $error("query taken but busy stayed low");

endmodule
